[hdl/crbs_pkg.sv]
`default_nettype none
package crbs_pkg;

   localparam int POSITION_BITS_DEF = 32;
   localparam int QUEUE_DEPTH_DEF   = 4;

   localparam int REG_BITS = 31;
   localparam int LEN_BITS = 28;

   // cigar op codes
   localparam logic [3:0] OP_M  = 4'd0;
   localparam logic [3:0] OP_I  = 4'd1;
   localparam logic [3:0] OP_D  = 4'd2;
   localparam logic [3:0] OP_N  = 4'd3;
   localparam logic [3:0] OP_EQ = 4'd7;
   localparam logic [3:0] OP_X  = 4'd8;

   // csr indexes
   localparam logic [1:0] CSR_WIN_START  = 2'd0;
   localparam logic [1:0] CSR_REF_END    = 2'd1;
   localparam logic [1:0] CSR_REF_ORIGIN = 2'd2;
   localparam logic [1:0] CSR_BASE_COUNT = 2'd3;

   // element classes
   localparam logic [1:0] CLS_INS = 2'd0;
   localparam logic [1:0] CLS_DEL = 2'd1;
   localparam logic [1:0] CLS_ALN = 2'd2;
   localparam logic [1:0] CLS_BAD = 2'd3;

   // result status
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_RANGE = 3'd1;
   localparam logic [2:0] ST_LEN_MISM  = 3'd2;
   localparam logic [2:0] ST_DEL_BOUND = 3'd3;
   localparam logic [2:0] ST_UNSUP     = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;

   typedef struct packed {
      logic [1:0]          cls;
      logic                ref_len;
      logic [LEN_BITS-1:0] len;
      logic                last;
   } item_type;

   typedef struct packed {
      logic [2:0] walk_status;
      logic       start_found;
      logic       walk_done;
   } flags_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [REG_BITS-1:0] base_start;
      logic [REG_BITS-1:0] base_length;
   } result_type;

endpackage
`default_nettype wire

[hdl/crbs_queue.sv]
`default_nettype none
module crbs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

[hdl/crbs_front.sv]
`default_nettype none
module crbs_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [1:0]                          csr_index,
   input  logic [crbs_pkg::REG_BITS-1:0]       csr_data,
   input  logic                                req_push,
   input  logic [3:0]                          req_op_code,
   input  logic [crbs_pkg::LEN_BITS-1:0]       req_op_length,
   input  logic                                req_last_element,
   input  logic                                queue_full,
   output logic                                queue_push,
   output crbs_pkg::item_type                  queue_item,
   output logic [crbs_pkg::REG_BITS-1:0]       win_start,
   output logic [crbs_pkg::REG_BITS-1:0]       ref_end,
   output logic [crbs_pkg::REG_BITS-1:0]       ref_origin,
   output logic [crbs_pkg::REG_BITS-1:0]       base_count
);
   import crbs_pkg::*;

   logic [REG_BITS-1:0] win_start_ff, ref_end_ff, ref_origin_ff, base_count_ff;

   assign win_start  = win_start_ff;
   assign ref_end    = ref_end_ff;
   assign ref_origin = ref_origin_ff;
   assign base_count = base_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff  <= '0;
         ref_end_ff    <= '0;
         ref_origin_ff <= '0;
         base_count_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WIN_START:  win_start_ff  <= csr_data;
            CSR_REF_END:    ref_end_ff    <= csr_data;
            CSR_REF_ORIGIN: ref_origin_ff <= csr_data;
            CSR_BASE_COUNT: base_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign queue_push = req_push && !queue_full;

   always_comb begin
      queue_item.len     = req_op_length;
      queue_item.last    = req_last_element;
      queue_item.ref_len = 1'b0;
      queue_item.cls     = CLS_BAD;
      case (req_op_code)
         OP_M, OP_EQ, OP_X: begin
            queue_item.cls     = CLS_ALN;
            queue_item.ref_len = 1'b1;
         end
         OP_D: begin
            queue_item.cls     = CLS_DEL;
            queue_item.ref_len = 1'b1;
         end
         OP_N: begin
            queue_item.ref_len = 1'b1;
         end
         OP_I: begin
            queue_item.cls = CLS_INS;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

[hdl/crbs_back.sv]
`default_nettype none
module crbs_back #(
   parameter int POSITION_BITS = crbs_pkg::POSITION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [crbs_pkg::REG_BITS-1:0]     win_start,
   input  logic [crbs_pkg::REG_BITS-1:0]     ref_end,
   input  logic [crbs_pkg::REG_BITS-1:0]     ref_origin,
   input  logic                              item_valid,
   input  crbs_pkg::item_type                item,
   output logic                              item_take,
   input  logic                              result_room,
   output logic                              job_valid,
   output crbs_pkg::flags_type               job_flags,
   output logic [POSITION_BITS-1:0]          job_sum,
   output logic [POSITION_BITS-1:0]          job_start_base,
   output logic [crbs_pkg::LEN_BITS-1:0]     job_start_off,
   output logic [POSITION_BITS-1:0]          job_stop_base,
   output logic [crbs_pkg::LEN_BITS-1:0]     job_stop_off
);
   import crbs_pkg::*;

   localparam int CW = (POSITION_BITS > REG_BITS) ? POSITION_BITS : REG_BITS;
   localparam int SW = ((POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS) + 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   function automatic logic [POSITION_BITS-1:0] sat_add(
      input logic [POSITION_BITS-1:0] a,
      input logic [LEN_BITS-1:0]      b
   );
      logic [SW-1:0] s;
      s = SW'(a) + SW'(b);
      return (s > SW'(POS_MAX)) ? POS_MAX : s[POSITION_BITS-1:0];
   endfunction

   logic                     job_open_ff, job_open_in;
   logic [POSITION_BITS-1:0] refpos_ff, refpos_in, basepos_ff, basepos_in;
   logic [POSITION_BITS-1:0] sum_ff, sum_in;
   flags_type                flags_ff, flags_in;
   logic [POSITION_BITS-1:0] start_base_ff, start_base_in, stop_base_ff, stop_base_in;
   logic [LEN_BITS-1:0]      start_off_ff, start_off_in, stop_off_ff, stop_off_in;

   logic [POSITION_BITS-1:0] rp, nx_rp, nx_base, nx_sum;
   flags_type                nx_flags;
   logic [POSITION_BITS-1:0] nx_start_base, nx_stop_base;
   logic [LEN_BITS-1:0]      nx_start_off, nx_stop_off;
   logic [CW-1:0]            s_diff, e_diff, len_c;
   logic                     s_hit, e_hit, walk_active;

   assign item_take = item_valid && (!item.last || result_room);

   always_comb begin
      rp     = job_open_ff ? refpos_ff : POSITION_BITS'(ref_origin);
      len_c  = CW'(item.len);
      s_diff = CW'(win_start) - CW'(rp);
      e_diff = CW'(ref_end) - CW'(rp);
      s_hit  = (CW'(win_start) >= CW'(rp)) && (s_diff < len_c);
      e_hit  = (CW'(ref_end) >= CW'(rp)) && (e_diff < len_c);
      walk_active = !flags_ff.walk_done && (flags_ff.walk_status == ST_OK);

      nx_rp         = rp;
      nx_base       = basepos_ff;
      nx_flags      = flags_ff;
      nx_start_base = start_base_ff;
      nx_start_off  = start_off_ff;
      nx_stop_base  = stop_base_ff;
      nx_stop_off   = stop_off_ff;
      nx_sum        = item.ref_len ? sat_add(sum_ff, item.len) : sum_ff;

      if (walk_active) begin
         case (item.cls)
            CLS_INS: begin
               nx_base = sat_add(basepos_ff, item.len);
            end
            CLS_DEL: begin
               if (s_hit || e_hit) begin
                  nx_flags.walk_status = ST_DEL_BOUND;
               end else begin
                  nx_rp = sat_add(rp, item.len);
               end
            end
            CLS_ALN: begin
               if (s_hit && (!e_hit || win_start <= ref_end)) begin
                  nx_start_base        = basepos_ff;
                  nx_start_off         = s_diff[LEN_BITS-1:0];
                  nx_flags.start_found = 1'b1;
               end
               if (e_hit) begin
                  nx_stop_base       = basepos_ff;
                  nx_stop_off        = e_diff[LEN_BITS-1:0];
                  nx_flags.walk_done = 1'b1;
               end else begin
                  nx_rp   = sat_add(rp, item.len);
                  nx_base = sat_add(basepos_ff, item.len);
               end
            end
            default: begin
               nx_flags.walk_status = ST_UNSUP;
            end
         endcase
      end
   end

   assign job_valid      = item_take && item.last;
   assign job_flags      = nx_flags;
   assign job_sum        = nx_sum;
   assign job_start_base = nx_start_base;
   assign job_start_off  = nx_start_off;
   assign job_stop_base  = nx_stop_base;
   assign job_stop_off   = nx_stop_off;

   always_comb begin
      job_open_in   = job_open_ff;
      refpos_in     = refpos_ff;
      basepos_in    = basepos_ff;
      sum_in        = sum_ff;
      flags_in      = flags_ff;
      start_base_in = nx_start_base;
      start_off_in  = nx_start_off;
      stop_base_in  = nx_stop_base;
      stop_off_in   = nx_stop_off;
      if (item_take) begin
         if (item.last) begin
            job_open_in = 1'b0;
            refpos_in   = '0;
            basepos_in  = '0;
            sum_in      = '0;
            flags_in    = '0;
         end else begin
            job_open_in = 1'b1;
            refpos_in   = nx_rp;
            basepos_in  = nx_base;
            sum_in      = nx_sum;
            flags_in    = nx_flags;
         end
      end else begin
         start_base_in = start_base_ff;
         start_off_in  = start_off_ff;
         stop_base_in  = stop_base_ff;
         stop_off_in   = stop_off_ff;
      end
   end

   always_ff @(posedge clock) begin
      start_base_ff <= start_base_in;
      start_off_ff  <= start_off_in;
      stop_base_ff  <= stop_base_in;
      stop_off_ff   <= stop_off_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_open_ff <= 1'b0;
         refpos_ff   <= '0;
         basepos_ff  <= '0;
         sum_ff      <= '0;
         flags_ff    <= '0;
      end else begin
         job_open_ff <= job_open_in;
         refpos_ff   <= refpos_in;
         basepos_ff  <= basepos_in;
         sum_ff      <= sum_in;
         flags_ff    <= flags_in;
      end
   end

endmodule
`default_nettype wire

[hdl/crbs_finish.sv]
`default_nettype none
module crbs_finish #(
   parameter int POSITION_BITS = crbs_pkg::POSITION_BITS_DEF,
   parameter int QUEUE_DEPTH   = crbs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [crbs_pkg::REG_BITS-1:0]      win_start,
   input  logic [crbs_pkg::REG_BITS-1:0]      ref_end,
   input  logic [crbs_pkg::REG_BITS-1:0]      base_count,
   input  logic                               job_valid,
   input  crbs_pkg::flags_type                job_flags,
   input  logic [POSITION_BITS-1:0]           job_sum,
   input  logic [POSITION_BITS-1:0]           job_start_base,
   input  logic [crbs_pkg::LEN_BITS-1:0]      job_start_off,
   input  logic [POSITION_BITS-1:0]           job_stop_base,
   input  logic [crbs_pkg::LEN_BITS-1:0]      job_stop_off,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_count,
   output logic                               result_room,
   output logic                               rsp_write,
   output crbs_pkg::result_type               rsp_item
);
   import crbs_pkg::*;

   localparam int CW  = (POSITION_BITS > REG_BITS) ? POSITION_BITS : REG_BITS;
   localparam int SW  = ((POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS) + 1;
   localparam int NW  = $clog2(QUEUE_DEPTH+1) + 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   function automatic logic [POSITION_BITS-1:0] sat_add(
      input logic [POSITION_BITS-1:0] a,
      input logic [LEN_BITS-1:0]      b
   );
      logic [SW-1:0] s;
      s = SW'(a) + SW'(b);
      return (s > SW'(POS_MAX)) ? POS_MAX : s[POSITION_BITS-1:0];
   endfunction

   logic                     a_valid_ff, b_valid_ff;
   flags_type                a_flags_ff;
   logic [POSITION_BITS-1:0] a_sum_ff, a_start_base_ff, a_stop_base_ff;
   logic [LEN_BITS-1:0]      a_start_off_ff, a_stop_off_ff;
   logic [2:0]               b_status_ff, b_status_in;
   logic [POSITION_BITS-1:0] b_start_ff, b_stop_ff;
   logic [POSITION_BITS:0]   span;

   // results already committed downstream must still fit in the queue
   assign result_room = (NW'(rsp_count) + NW'(a_valid_ff) + NW'(b_valid_ff))
                        < NW'(QUEUE_DEPTH);

   always_comb begin
      if (ref_end < win_start) begin
         b_status_in = ST_BAD_RANGE;
      end else if (CW'(a_sum_ff) != CW'(base_count)) begin
         b_status_in = ST_LEN_MISM;
      end else if (a_flags_ff.walk_status != ST_OK) begin
         b_status_in = a_flags_ff.walk_status;
      end else if (!a_flags_ff.start_found || !a_flags_ff.walk_done) begin
         b_status_in = ST_NOT_FOUND;
      end else begin
         b_status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      a_flags_ff      <= job_flags;
      a_sum_ff        <= job_sum;
      a_start_base_ff <= job_start_base;
      a_start_off_ff  <= job_start_off;
      a_stop_base_ff  <= job_stop_base;
      a_stop_off_ff   <= job_stop_off;
      b_status_ff     <= b_status_in;
      b_start_ff      <= sat_add(a_start_base_ff, a_start_off_ff);
      b_stop_ff       <= sat_add(a_stop_base_ff, a_stop_off_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= job_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_comb begin
      span = (b_stop_ff >= b_start_ff)
             ? ((POSITION_BITS+1)'(b_stop_ff) - (POSITION_BITS+1)'(b_start_ff)
                + (POSITION_BITS+1)'(1))
             : '0;
      rsp_write       = b_valid_ff;
      rsp_item.status = b_status_ff;
      if (b_status_ff == ST_OK) begin
         rsp_item.base_start  = REG_BITS'(b_start_ff);
         rsp_item.base_length = REG_BITS'(span);
      end else begin
         rsp_item.base_start  = '0;
         rsp_item.base_length = '0;
      end
   end

endmodule
`default_nettype wire

[hdl/cigar_ref_interval_to_base_span_top.sv]
`default_nettype none
// channel | ports                                        | transfer when
// req     | req_op_code, req_op_length, req_last_element | req_push && !req_full
// rsp     | rsp_status, rsp_base_start, rsp_base_length  | rsp_pop && !rsp_empty
// csr     | csr_index, csr_data                          | csr_write_enable
//
// One cigar element per cycle while req_full is low; the back end walks one element
// a cycle from the element queue. A result passes from the walk of its last
// element through a two-stage finish pipeline into the result queue.
// The walk stalls on a last element only while the result queue lacks room.
// Synchronous active-high reset clears the queues and walk position, sum, flags.
module cigar_ref_interval_to_base_span_top #(
   parameter int POSITION_BITS = crbs_pkg::POSITION_BITS_DEF,
   parameter int QUEUE_DEPTH   = crbs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [1:0]                        csr_index,
   input  logic [crbs_pkg::REG_BITS-1:0]     csr_data,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [3:0]                        req_op_code,
   input  logic [crbs_pkg::LEN_BITS-1:0]     req_op_length,
   input  logic                              req_last_element,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [2:0]                        rsp_status,
   output logic [crbs_pkg::REG_BITS-1:0]     rsp_base_start,
   output logic [crbs_pkg::REG_BITS-1:0]     rsp_base_length
);
   import crbs_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

   logic [REG_BITS-1:0]      win_start, ref_end, ref_origin, base_count;
   logic                     item_push, item_full, item_empty, item_take;
   item_type                 item_in, item_out;
   logic [CNT_W-1:0]         item_count, rsp_count;
   logic                     result_room, job_valid, rsp_write, rsp_full;
   flags_type                job_flags;
   logic [POSITION_BITS-1:0] job_sum, job_start_base, job_stop_base;
   logic [LEN_BITS-1:0]      job_start_off, job_stop_off;
   result_type               rsp_in, rsp_out;
   logic                     item_count_unused, rsp_full_unused;

   assign req_full = item_full;

   crbs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_push         (req_push),
      .req_op_code      (req_op_code),
      .req_op_length    (req_op_length),
      .req_last_element (req_last_element),
      .queue_full       (item_full),
      .queue_push       (item_push),
      .queue_item       (item_in),
      .win_start        (win_start),
      .ref_end          (ref_end),
      .ref_origin       (ref_origin),
      .base_count       (base_count)
   );

   crbs_queue #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_push),
      .push_data (item_in),
      .pop       (item_take),
      .pop_data  (item_out),
      .full      (item_full),
      .empty     (item_empty),
      .count     (item_count)
   );

   assign item_count_unused = |item_count;

   crbs_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .win_start      (win_start),
      .ref_end        (ref_end),
      .ref_origin     (ref_origin),
      .item_valid     (!item_empty),
      .item           (item_out),
      .item_take      (item_take),
      .result_room    (result_room),
      .job_valid      (job_valid),
      .job_flags      (job_flags),
      .job_sum        (job_sum),
      .job_start_base (job_start_base),
      .job_start_off  (job_start_off),
      .job_stop_base  (job_stop_base),
      .job_stop_off   (job_stop_off)
   );

   crbs_finish #(
      .POSITION_BITS (POSITION_BITS),
      .QUEUE_DEPTH   (QUEUE_DEPTH)
   ) u_finish (
      .clock          (clock),
      .reset          (reset),
      .win_start      (win_start),
      .ref_end        (ref_end),
      .base_count     (base_count),
      .job_valid      (job_valid),
      .job_flags      (job_flags),
      .job_sum        (job_sum),
      .job_start_base (job_start_base),
      .job_start_off  (job_start_off),
      .job_stop_base  (job_stop_base),
      .job_stop_off   (job_stop_off),
      .rsp_count      (rsp_count),
      .result_room    (result_room),
      .rsp_write      (rsp_write),
      .rsp_item       (rsp_in)
   );

   crbs_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_write),
      .push_data (rsp_in),
      .pop       (rsp_pop),
      .pop_data  (rsp_out),
      .full      (rsp_full),
      .empty     (rsp_empty),
      .count     (rsp_count)
   );

   assign rsp_full_unused = rsp_full;

   assign rsp_status      = rsp_out.status;
   assign rsp_base_start  = rsp_out.base_start;
   assign rsp_base_length = rsp_out.base_length;

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import crbs_pkg::*;

   localparam int          PB            = POSITION_BITS_DEF;
   localparam logic [63:0] POS_MAX       = (64'd1 << PB) - 64'd1;
   localparam logic [63:0] REG_MAX       = 64'h7FFF_FFFF;
   localparam logic [63:0] LEN_MAX       = 64'h0FFF_FFFF;
   localparam int          RANDOM_ELEMS  = 1950;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          SETTLE_CYCLES = 20;
   localparam int          HOLD_CYCLES   = 500;

   localparam logic [3:0] OP_S           = 4'd4;
   localparam logic [3:0] OP_H           = 4'd5;
   localparam logic [3:0] OP_P           = 4'd6;
   localparam logic [3:0] OP_B           = 4'd9;
   localparam logic [3:0] OP_RESERVED_LO = 4'd10;

   typedef struct packed {
      logic [3:0]          op;
      logic [LEN_BITS-1:0] len;
      logic                last;
   } cigar_elem_type;

   typedef enum {POP_ALWAYS, POP_HALF, POP_QUARTER, POP_PATTERN} pop_mode_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [1:0]          csr_index        = CSR_WIN_START;
   logic [REG_BITS-1:0] csr_data         = '0;
   logic                req_push         = 1'b0;
   logic                req_full;
   logic [3:0]          req_op_code      = OP_M;
   logic [LEN_BITS-1:0] req_op_length    = '0;
   logic                req_last_element = 1'b0;
   logic                rsp_empty;
   logic                rsp_pop          = 1'b0;
   logic [2:0]          rsp_status;
   logic [REG_BITS-1:0] rsp_base_start;
   logic [REG_BITS-1:0] rsp_base_length;

   cigar_ref_interval_to_base_span_top u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_op_code      (req_op_code),
      .req_op_length    (req_op_length),
      .req_last_element (req_last_element),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_status       (rsp_status),
      .rsp_base_start   (rsp_base_start),
      .rsp_base_length  (rsp_base_length)
   );

   // register copies and walk state of the span mapper
   logic [63:0] reg_start = '0, reg_end = '0, reg_origin = '0, reg_count = '0;
   logic [63:0] ref_pos = '0, base_pos = '0, start_idx = '0, stop_idx = '0, ref_sum = '0;
   logic        start_hit = 1'b0, stop_hit = 1'b0, job_open = 1'b0;
   logic [2:0]  walk_err = ST_OK;

   result_type     span_due[$];
   cigar_elem_type cigar_backlog[$];
   cigar_elem_type offered;
   result_type     span_want;

   int           mismatch_count = 0;
   int           spans_checked  = 0;
   int           cycle_count    = 0;
   int           burst_left     = 0;
   int           gap_left       = 0;
   int           hold_left      = 0;
   bit           hold_done      = 1'b0;
   int           mode_left      = 0;
   pop_mode_type pop_mode       = POP_ALWAYS;
   logic [7:0]   pop_pattern    = 8'hFF;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > POS_MAX) ? POS_MAX : s;
   endfunction

   function automatic bit in_span(input logic [63:0] p, input logic [63:0] lo,
                                  input logic [63:0] len);
      return (p >= lo) && ((p - lo) < len);
   endfunction

   function automatic void map_element(input cigar_elem_type e);
      logic [63:0] len;
      logic [63:0] span_len;
      logic        aligned;
      logic        end_in;
      result_type  span;
      len     = {36'd0, e.len};
      aligned = (e.op == OP_M) || (e.op == OP_EQ) || (e.op == OP_X);
      if (!job_open) begin
         ref_pos  = reg_origin;
         job_open = 1'b1;
      end
      if (aligned || e.op == OP_D || e.op == OP_N)
         ref_sum = sat_add(ref_sum, len);
      if (!stop_hit && walk_err == ST_OK) begin
         if (e.op == OP_I) begin
            base_pos = sat_add(base_pos, len);
         end else if (e.op == OP_D) begin
            if (in_span(reg_start, ref_pos, len) || in_span(reg_end, ref_pos, len))
               walk_err = ST_DEL_BOUND;
            else
               ref_pos = sat_add(ref_pos, len);
         end else if (aligned) begin
            end_in = in_span(reg_end, ref_pos, len);
            if (in_span(reg_start, ref_pos, len) && (!end_in || reg_start <= reg_end)) begin
               start_idx = sat_add(base_pos, reg_start - ref_pos);
               start_hit = 1'b1;
            end
            if (end_in) begin
               stop_idx = sat_add(base_pos, reg_end - ref_pos);
               stop_hit = 1'b1;
            end else begin
               ref_pos  = sat_add(ref_pos, len);
               base_pos = sat_add(base_pos, len);
            end
         end else begin
            walk_err = ST_UNSUP;
         end
      end
      if (e.last) begin
         span = '0;
         if (reg_end < reg_start)
            span.status = ST_BAD_RANGE;
         else if (ref_sum != reg_count)
            span.status = ST_LEN_MISM;
         else if (walk_err != ST_OK)
            span.status = walk_err;
         else if (!start_hit || !stop_hit)
            span.status = ST_NOT_FOUND;
         else
            span.status = ST_OK;
         if (span.status == ST_OK) begin
            span_len         = (stop_idx >= start_idx) ? stop_idx - start_idx + 64'd1 : 64'd0;
            span.base_start  = start_idx[REG_BITS-1:0];
            span.base_length = span_len[REG_BITS-1:0];
         end
         span_due.push_back(span);
         ref_pos   = '0;
         base_pos  = '0;
         start_idx = '0;
         stop_idx  = '0;
         ref_sum   = '0;
         start_hit = 1'b0;
         stop_hit  = 1'b0;
         walk_err  = ST_OK;
         job_open  = 1'b0;
      end
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= value[REG_BITS-1:0];
      case (idx)
         CSR_WIN_START:  reg_start  = value & REG_MAX;
         CSR_REF_END:    reg_end    = value & REG_MAX;
         CSR_REF_ORIGIN: reg_origin = value & REG_MAX;
         default:        reg_count  = value & REG_MAX;
      endcase
   endtask

   task automatic set_window(input logic [63:0] s, input logic [63:0] e,
                             input logic [63:0] o, input logic [63:0] c);
      write_reg(CSR_WIN_START, s);
      write_reg(CSR_REF_END, e);
      write_reg(CSR_REF_ORIGIN, o);
      write_reg(CSR_BASE_COUNT, c);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic push_elem(input logic [3:0] op, input logic [63:0] len, input logic last);
      cigar_elem_type e;
      e.op   = op;
      e.len  = len[LEN_BITS-1:0];
      e.last = last;
      cigar_backlog.push_back(e);
   endtask

   // idle point: nothing queued, nothing on the port, no result outstanding
   task automatic settle();
      while (cigar_backlog.size() != 0 || req_push || span_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pick_window(input int phase);
      logic [63:0] s, e, o, c;
      if (phase == 0) begin
         s = 0; e = 0; o = 0; c = 0;
      end else if (phase == 1) begin
         s = REG_MAX; e = REG_MAX; o = REG_MAX; c = REG_MAX;
      end else if ($urandom_range(0, 5) == 0) begin
         o = 64'($urandom_range(0, 32'h3FFF_FFFF));
         c = 64'($urandom_range(32'h1000_0000, 32'h7FFF_FFFF));
         s = 64'($urandom_range(o[31:0], 32'h7FFF_FFFF));
         e = 64'($urandom_range(s[31:0], 32'h7FFF_FFFF));
      end else begin
         o = 64'($urandom_range(0, 300));
         c = 64'($urandom_range(1, 200));
         s = o + 64'($urandom_range(0, c[31:0] + 9));
         s = (s >= 4) ? s - 4 : 0;
         if ($urandom_range(0, 9) == 0)
            e = (s == 0) ? 0 : 64'($urandom_range(0, s[31:0] - 1));
         else
            e = s + 64'($urandom_range(0, c[31:0]));
      end
      set_window(s, e, o, c);
   endtask

   task automatic queue_job(output int count);
      cigar_elem_type job[$];
      cigar_elem_type e;
      logic [63:0] target, left, piece, chunk;
      int          kind, pieces, n, r, inject_at;
      kind   = $urandom_range(0, 99);
      target = reg_count;
      e.last = 1'b0;
      if (kind >= 70 && kind < 78) begin
         if (target > 0 && $urandom_range(0, 1) == 1)
            target = target - 1;
         else
            target = target + 64'($urandom_range(1, 9));
      end
      if (kind >= 86 && kind < 94) begin
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) begin
            e.op  = 4'($urandom_range(0, 15));
            e.len = ($urandom_range(0, 1) == 1)
                    ? LEN_BITS'($urandom_range(0, LEN_MAX[31:0]))
                    : LEN_BITS'($urandom_range(0, 40));
            job.push_back(e);
         end
      end else if (kind >= 94 && kind < 97) begin
         // long run of near-maximum elements, drives positions and sum into saturation
         n = $urandom_range(17, 19);
         for (int i = 0; i < n; i++) begin
            r     = $urandom_range(0, 7);
            e.op  = (r == 0) ? OP_D : (r == 1) ? OP_X : (r == 2) ? OP_EQ : OP_M;
            e.len = LEN_BITS'($urandom_range(32'h0FF0_0000, LEN_MAX[31:0]));
            job.push_back(e);
         end
      end else begin
         pieces    = $urandom_range(1, 5);
         inject_at = (kind >= 62 && kind < 70) ? int'($urandom_range(0, pieces)) : -1;
         left      = target;
         for (int i = 0; i <= pieces; i++) begin
            if (i == inject_at) begin
               r = $urandom_range(0, 10);
               case (r)
                  0:       e.op = OP_N;
                  1:       e.op = OP_S;
                  2:       e.op = OP_H;
                  3:       e.op = OP_P;
                  4:       e.op = OP_B;
                  default: e.op = OP_RESERVED_LO + 4'(r - 5);
               endcase
               e.len = LEN_BITS'($urandom_range(0, 30));
               job.push_back(e);
            end
            if (i == pieces)
               break;
            if (kind >= 78 && kind < 86 && $urandom_range(0, 1) == 1) begin
               r     = $urandom_range(0, 3);
               e.op  = (r == 0) ? OP_I : (r == 1) ? OP_D : (r == 2) ? OP_X : OP_M;
               e.len = '0;
               job.push_back(e);
            end
            if ($urandom_range(0, 3) == 0) begin
               e.op  = OP_I;
               e.len = (reg_count > 1000) ? LEN_BITS'($urandom_range(1, LEN_MAX[31:0]))
                                          : LEN_BITS'($urandom_range(1, 20));
               job.push_back(e);
            end
            piece = (i == pieces - 1) ? left : 64'($urandom_range(0, left[31:0]));
            left  = left - piece;
            r     = $urandom_range(0, 11);
            e.op  = (r < 2) ? OP_D : (r < 5) ? OP_EQ : (r < 7) ? OP_X : OP_M;
            do begin
               chunk = (piece > LEN_MAX) ? LEN_MAX : piece;
               e.len = chunk[LEN_BITS-1:0];
               job.push_back(e);
               piece = piece - chunk;
            end while (piece != 0);
         end
      end
      for (int i = 0; i < job.size(); i++) begin
         e      = job[i];
         e.last = (i == job.size() - 1);
         cigar_backlog.push_back(e);
      end
      count = job.size();
   endtask

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full)
            map_element(offered);
         if (!req_push || !req_full) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_push <= 1'b0;
            end else if (cigar_backlog.size() != 0) begin
               offered = cigar_backlog.pop_front();
               req_push         <= 1'b1;
               req_op_code      <= offered.op;
               req_op_length    <= offered.len;
               req_last_element <= offered.last;
               if (burst_left > 1) begin
                  burst_left = burst_left - 1;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each transfer, stalls on its own pattern, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (span_due.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("unexpected result: status %0d start %0d length %0d",
                           rsp_status, rsp_base_start, rsp_base_length);
            end else begin
               span_want     = span_due.pop_front();
               spans_checked = spans_checked + 1;
               if (rsp_status !== span_want.status || rsp_base_start !== span_want.base_start
                   || rsp_base_length !== span_want.base_length) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("result %0d exp %0d %0d %0d got %0d %0d %0d",
                              spans_checked, span_want.status, span_want.base_start,
                              span_want.base_length, rsp_status, rsp_base_start,
                              rsp_base_length);
               end
            end
         end
         if (!hold_done && spans_checked >= 60 && cigar_backlog.size() > 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            pop_mode    = pop_mode_type'($urandom_range(0, 3));
            mode_left   = $urandom_range(50, 200);
            pop_pattern = 8'($urandom_range(1, 255));
         end else begin
            mode_left = mode_left - 1;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_pop <= 1'b0;
         end else begin
            case (pop_mode)
               POP_ALWAYS:  rsp_pop <= 1'b1;
               POP_HALF:    rsp_pop <= 1'($urandom_range(0, 1));
               POP_QUARTER: rsp_pop <= ($urandom_range(0, 3) == 0);
               default:     rsp_pop <= pop_pattern[cycle_count[2:0]];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int elems;
      int phase_end;
      int phase;
      int got;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // window 10..19, alignment from 5, 30 reference bases
      set_window(10, 19, 5, 30);
      push_elem(OP_M, 30, 1'b1);
      push_elem(OP_I, 3, 1'b0);
      push_elem(OP_M, 12, 1'b0);
      push_elem(OP_D, 2, 1'b0);
      push_elem(OP_EQ, 16, 1'b1);
      push_elem(OP_M, 3, 1'b0);
      push_elem(OP_D, 5, 1'b0);
      push_elem(OP_X, 22, 1'b1);
      push_elem(OP_M, 10, 1'b0);
      push_elem(OP_N, 20, 1'b1);
      push_elem(OP_M, 29, 1'b1);
      push_elem(OP_EQ, 0, 1'b0);
      push_elem(OP_M, 30, 1'b1);
      push_elem(OP_M, 20, 1'b0);
      push_elem(OP_M, 10, 1'b1);
      push_elem(OP_S, 0, 1'b0);
      push_elem(OP_M, 30, 1'b1);
      settle();

      // end before start
      set_window(20, 3, 0, 25);
      push_elem(OP_H, 5, 1'b0);
      push_elem(OP_P, 2, 1'b0);
      push_elem(OP_M, 25, 1'b1);
      settle();

      // start before the origin
      set_window(2, 9, 4, 10);
      push_elem(OP_B, 1, 1'b0);
      push_elem(OP_M, 10, 1'b1);
      push_elem(OP_M, 10, 1'b1);
      settle();

      elems = 0;
      phase = 0;
      while (elems < RANDOM_ELEMS) begin
         pick_window(phase);
         phase_end = elems + $urandom_range(60, 140);
         while (elems < phase_end) begin
            queue_job(got);
            elems = elems + got;
         end
         settle();
         phase = phase + 1;
      end

      if (mismatch_count == 0 && span_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
hdl/crbs_pkg.sv
hdl/crbs_queue.sv
hdl/crbs_front.sv
hdl/crbs_back.sv
hdl/crbs_finish.sv
hdl/cigar_ref_interval_to_base_span_top.sv
tb/testbench.sv
